// ----- rtl/rar_pkg.sv -----
// ----------------------------------------------------------------------------
// rar_pkg
// Shared constants and types of the rational arithmetic reduce block.
// ----------------------------------------------------------------------------
package rar_pkg;

    // Default operand width; the top level hands its own value down
    localparam int unsigned OPERAND_WIDTH_DEF = 16;

    // Fixed result field widths
    localparam int unsigned RES_NUM_W = 33;
    localparam int unsigned RES_DEN_W = 31;
    localparam int unsigned ACTION_W  = 2;

    // Operation codes; the fourth code is unused and flags an error
    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD = 2'd0,
        ACT_MUL = 2'd1,
        ACT_DIV = 2'd2
    } t_action;

    // Shared add/subtract unit operation
    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

endpackage

// ----- rtl/rar_if.sv -----
// ----------------------------------------------------------------------------
// rar_if
// Valid/ready channels of the rational arithmetic reduce block: operand
// words in, reduced fraction words out.
// ----------------------------------------------------------------------------

// Operand channel
interface rar_in_if #(
    parameter int unsigned OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
);
    logic                              valid;
    logic                              ready;
    logic [rar_pkg::ACTION_W-1:0]      action;
    logic signed [OPERAND_WIDTH-1:0]   a_num;
    logic signed [OPERAND_WIDTH-1:0]   a_den;
    logic signed [OPERAND_WIDTH-1:0]   b_num;
    logic signed [OPERAND_WIDTH-1:0]   b_den;

    modport source (
        output valid, action, a_num, a_den, b_num, b_den,
        input  ready
    );
    modport sink (
        input  valid, action, a_num, a_den, b_num, b_den,
        output ready
    );
endinterface

// Result channel
interface rar_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [rar_pkg::RES_NUM_W-1:0]  res_num;
    logic [rar_pkg::RES_DEN_W-1:0]         res_den;
    logic                                  error;

    modport source (
        output valid, res_num, res_den, error,
        input  ready
    );
    modport sink (
        input  valid, res_num, res_den, error,
        output ready
    );
endinterface

// ----- rtl/rar_mul.sv -----
// ----------------------------------------------------------------------------
// rar_mul
// Registered unsigned multiplier for operand magnitudes.
// ----------------------------------------------------------------------------
module rar_mul #(
    parameter int unsigned WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic [WIDTH-1:0]     i_a,
    input  logic [WIDTH-1:0]     i_b,
    output logic [2*WIDTH-1:0]   o_prod
);
    logic [2*WIDTH-1:0] r_prod;
    logic [2*WIDTH-1:0] n_prod;

    // Full-width product of the two magnitudes
    assign n_prod = {{WIDTH{1'b0}}, i_a} * {{WIDTH{1'b0}}, i_b};

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;

endmodule

// ----- rtl/rar_alu.sv -----
// ----------------------------------------------------------------------------
// rar_alu
// Shared add/subtract unit. The extra top bit of the result is the carry
// on add and the borrow (a < b) on subtract.
// ----------------------------------------------------------------------------
module rar_alu #(
    parameter int unsigned WIDTH = 2 * rar_pkg::OPERAND_WIDTH_DEF + 1
) (
    input  rar_pkg::t_alu_op   i_op,
    input  logic [WIDTH-1:0]   i_a,
    input  logic [WIDTH-1:0]   i_b,
    output logic [WIDTH:0]     o_res
);
    import rar_pkg::*;

    logic [WIDTH:0] a_ext;
    logic [WIDTH:0] b_opnd;
    logic           cin;

    // a + b, or a + ~b + 1 for subtract
    always_comb begin
        cin    = (i_op == ALU_SUB);
        a_ext  = {1'b0, i_a};
        b_opnd = cin ? ~{1'b0, i_b} : {1'b0, i_b};
        o_res  = a_ext + b_opnd + {{WIDTH{1'b0}}, cin};
    end

endmodule

// ----- rtl/rational_arith_reduce_top.sv -----
// ----------------------------------------------------------------------------
// rational_arith_reduce_top
// Adds, multiplies or divides two signed fractions and reduces the result
// by the gcd of numerator and denominator, sign carried by the numerator.
//
//   channel | dir | handshake     | word
//   --------+-----+---------------+------------------------------------------
//   i_in    | in  | valid/ready   | action, a_num, a_den, b_num, b_den
//   o_out   | out | valid/ready   | res_num, res_den, error
//
// One word at a time. An error word goes from idle straight to the done state and
// is loaded into the output register from there; a zero numerator first passes
// the four multiply states and the sum. Others: the multiply states, one or two
// sum states, a binary gcd loop of one subtract, shift or swap per cycle (data
// dependent), two restoring divisions and the load. i_in.ready is high only
// while idle; a done word waits while the output register is full.
// Reset is synchronous, active low, and clears control only.
// ----------------------------------------------------------------------------
module rational_arith_reduce_top #(
    parameter int unsigned OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rar_in_if.sink      i_in,
    rar_out_if.source   o_out
);
    import rar_pkg::*;

    localparam int unsigned W  = OPERAND_WIDTH;
    localparam int unsigned MW = 2 * W;          // product / sum magnitude
    localparam int unsigned AW = MW + 1;         // shared unit width
    localparam int unsigned KW = $clog2(MW + 1); // common power of two count
    localparam int unsigned CW = $clog2(MW);     // division bit index
    localparam int unsigned NW = (MW > RES_NUM_W) ? MW : RES_NUM_W;
    localparam int unsigned DW = (MW > RES_DEN_W) ? MW : RES_DEN_W;

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_MUL0 = 11'b000_0000_0010,
        S_MUL1 = 11'b000_0000_0100,
        S_MUL2 = 11'b000_0000_1000,
        S_MUL3 = 11'b000_0001_0000,
        S_SUM  = 11'b000_0010_0000,
        S_SUBR = 11'b000_0100_0000,
        S_GCD  = 11'b000_1000_0000,
        S_DIVN = 11'b001_0000_0000,
        S_DIVD = 11'b010_0000_0000,
        S_DONE = 11'b100_0000_0000
    } t_state;

    // Two's complement to magnitude; the most negative value maps to 2^(W-1)
    function automatic logic [W-1:0] f_mag(input logic [W-1:0] v);
        f_mag = v[W-1] ? (~v + {{(W-1){1'b0}}, 1'b1}) : v;
    endfunction

    // Control state
    t_state          r_state, n_state;
    logic            r_out_valid, n_out_valid;

    // Operand and working registers
    t_action         r_act, n_act;
    logic            r_an_s, r_ad_s, r_bn_s, r_bd_s;
    logic            n_an_s, n_ad_s, n_bn_s, n_bd_s;
    logic [W-1:0]    r_an, r_ad, r_bn, r_bd;
    logic [W-1:0]    n_an, n_ad, n_bn, n_bd;
    logic [MW-1:0]   r_p1, r_p2, n_p1, n_p2;
    logic [MW-1:0]   r_nm, r_dm, n_nm, n_dm;
    logic            r_neg, n_neg;
    logic            r_err, n_err;
    logic [MW-1:0]   r_u, r_v, n_u, n_v;
    logic [KW-1:0]   r_k, n_k;
    logic [MW-1:0]   r_g, n_g;
    logic [MW-1:0]   r_x, r_rem, n_x, n_rem;
    logic [CW-1:0]   r_cnt, n_cnt;

    // Output register
    logic [RES_NUM_W-1:0] r_res_num;
    logic [RES_DEN_W-1:0] r_res_den;
    logic                 r_res_err;
    logic                 out_load;

    // Shared units
    logic [W-1:0]    mul_a, mul_b;
    logic [MW-1:0]   mul_prod;
    t_alu_op         alu_op;
    logic [AW-1:0]   alu_a, alu_b;
    logic [AW:0]     alu_res;
    logic            alu_borrow;

    // Decoded input word
    logic            in_take;
    logic            in_err;
    logic            act_bad;
    t_action         in_act;

    // Product signs
    logic            s_p1, s_p2, s_den;

    // Sum result select
    logic            nm_rdy;
    logic [MW-1:0]   nm_sel;
    logic            sgn_sel;

    // Division step
    logic [MW-1:0]   q_next;
    logic [MW-1:0]   rem_next;

    // Output formatting
    logic [NW-1:0]   nm_ext, num_sgn;
    logic [DW-1:0]   dm_ext;

    rar_mul #(.WIDTH(W)) u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    rar_alu #(.WIDTH(AW)) u_alu (
        .i_op   (alu_op),
        .i_a    (alu_a),
        .i_b    (alu_b),
        .o_res  (alu_res)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign in_take    = i_in.valid && (r_state == S_IDLE);
    assign in_act     = t_action'(i_in.action);
    assign act_bad    = (in_act != ACT_ADD) && (in_act != ACT_MUL) && (in_act != ACT_DIV);
    assign in_err     = act_bad || (i_in.a_den == '0) || (i_in.b_den == '0) ||
                        ((in_act == ACT_DIV) && (i_in.b_num == '0));

    // Signs of the partial products and of the denominator product
    assign s_p1  = r_an_s ^ ((r_act == ACT_MUL) ? r_bn_s : r_bd_s);
    assign s_p2  = r_bn_s ^ r_ad_s;
    assign s_den = r_ad_s ^ ((r_act == ACT_DIV) ? r_bn_s : r_bd_s);

    // Multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MUL0: begin
                mul_a = r_an;
                mul_b = (r_act == ACT_MUL) ? r_bn : r_bd;
            end
            S_MUL1: begin
                mul_a = r_bn;
                mul_b = r_ad;
            end
            S_MUL2: begin
                mul_a = r_ad;
                mul_b = (r_act == ACT_DIV) ? r_bn : r_bd;
            end
            default: begin
            end
        endcase
    end

    // Add/subtract operand select
    always_comb begin
        alu_op = ALU_SUB;
        alu_a  = '0;
        alu_b  = '0;
        case (r_state)
            S_SUM: begin
                alu_op = (s_p1 == s_p2) ? ALU_ADD : ALU_SUB;
                alu_a  = AW'(r_p1);
                alu_b  = AW'(r_p2);
            end
            S_SUBR: begin
                alu_a = AW'(r_p2);
                alu_b = AW'(r_p1);
            end
            S_GCD: begin
                alu_a = AW'(r_u);
                alu_b = AW'(r_v);
            end
            S_DIVN, S_DIVD: begin
                alu_a = {r_rem, r_x[MW-1]};
                alu_b = AW'(r_g);
            end
            default: begin
            end
        endcase
    end

    assign alu_borrow = alu_res[AW];

    // One restoring division step: trial subtract of the divisor
    assign q_next   = {r_x[MW-2:0], ~alu_borrow};
    assign rem_next = alu_borrow ? {r_rem[MW-2:0], r_x[MW-1]} : alu_res[MW-1:0];

    // Output word formatting
    assign nm_ext  = NW'(r_nm);
    assign num_sgn = r_neg ? (~nm_ext + NW'(1)) : nm_ext;
    assign dm_ext  = DW'(r_dm);
    assign out_load = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_act   = r_act;
        n_an_s  = r_an_s;
        n_ad_s  = r_ad_s;
        n_bn_s  = r_bn_s;
        n_bd_s  = r_bd_s;
        n_an    = r_an;
        n_ad    = r_ad;
        n_bn    = r_bn;
        n_bd    = r_bd;
        n_p1    = r_p1;
        n_p2    = r_p2;
        n_nm    = r_nm;
        n_dm    = r_dm;
        n_neg   = r_neg;
        n_err   = r_err;
        n_u     = r_u;
        n_v     = r_v;
        n_k     = r_k;
        n_g     = r_g;
        n_x     = r_x;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        nm_rdy  = 1'b0;
        nm_sel  = r_p1;
        sgn_sel = s_p1;

        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_act  = in_act;
                    n_an_s = i_in.a_num[W-1];
                    n_ad_s = i_in.a_den[W-1];
                    n_bn_s = i_in.b_num[W-1];
                    n_bd_s = i_in.b_den[W-1];
                    n_an   = f_mag(W'(i_in.a_num));
                    n_ad   = f_mag(W'(i_in.a_den));
                    n_bn   = f_mag(W'(i_in.b_num));
                    n_bd   = f_mag(W'(i_in.b_den));
                    n_err  = in_err;
                    if (in_err) begin
                        n_nm    = '0;
                        n_dm    = '0;
                        n_neg   = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_MUL0;
                    end
                end
            end
            S_MUL0: n_state = S_MUL1;
            S_MUL1: begin
                n_p1    = mul_prod;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_p2    = mul_prod;
                n_state = S_MUL3;
            end
            S_MUL3: begin
                n_dm    = mul_prod;
                n_state = S_SUM;
            end
            // Numerator: p1 alone, or the signed sum of p1 and p2
            S_SUM: begin
                if (r_act != ACT_ADD) begin
                    nm_rdy = 1'b1;
                end else if ((alu_op == ALU_ADD) || !alu_borrow) begin
                    nm_rdy = 1'b1;
                    nm_sel = alu_res[MW-1:0];
                end else begin
                    n_state = S_SUBR;
                end
            end
            S_SUBR: begin
                nm_rdy  = 1'b1;
                nm_sel  = alu_res[MW-1:0];
                sgn_sel = s_p2;
            end
            // Binary gcd, one shift, subtract or swap per cycle
            S_GCD: begin
                if (alu_res == '0) begin
                    n_g     = r_u << r_k;
                    n_x     = r_nm;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = S_DIVN;
                end else if (!r_u[0] && !r_v[0]) begin
                    n_u = r_u >> 1;
                    n_v = r_v >> 1;
                    n_k = r_k + KW'(1);
                end else if (!r_u[0]) begin
                    n_u = r_u >> 1;
                end else if (!r_v[0]) begin
                    n_v = r_v >> 1;
                end else if (!alu_borrow) begin
                    n_u = alu_res[MW-1:0] >> 1;
                end else begin
                    n_u = r_v;
                    n_v = r_u;
                end
            end
            // Numerator divided by the gcd
            S_DIVN: begin
                n_x   = q_next;
                n_rem = rem_next;
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(MW - 1)) begin
                    n_nm    = q_next;
                    n_x     = r_dm;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = S_DIVD;
                end
            end
            // Denominator divided by the gcd
            S_DIVD: begin
                n_x   = q_next;
                n_rem = rem_next;
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(MW - 1)) begin
                    n_dm    = q_next;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // Numerator known: zero goes out unreduced, otherwise start the gcd
        if (nm_rdy) begin
            n_nm  = nm_sel;
            n_neg = (nm_sel != '0) && (sgn_sel ^ s_den);
            n_u   = nm_sel;
            n_v   = r_dm;
            n_k   = '0;
            n_state = (nm_sel == '0) ? S_DONE : S_GCD;
        end
    end

    // Output register handshake
    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_act  <= n_act;
        r_an_s <= n_an_s;
        r_ad_s <= n_ad_s;
        r_bn_s <= n_bn_s;
        r_bd_s <= n_bd_s;
        r_an   <= n_an;
        r_ad   <= n_ad;
        r_bn   <= n_bn;
        r_bd   <= n_bd;
        r_p1   <= n_p1;
        r_p2   <= n_p2;
        r_nm   <= n_nm;
        r_dm   <= n_dm;
        r_neg  <= n_neg;
        r_err  <= n_err;
        r_u    <= n_u;
        r_v    <= n_v;
        r_k    <= n_k;
        r_g    <= n_g;
        r_x    <= n_x;
        r_rem  <= n_rem;
        r_cnt  <= n_cnt;
        if (out_load) begin
            r_res_num <= num_sgn[RES_NUM_W-1:0];
            r_res_den <= dm_ext[RES_DEN_W-1:0];
            r_res_err <= r_err;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.res_num = r_res_num;
    assign o_out.res_den = r_res_den;
    assign o_out.error   = r_res_err;

    // An accepted word always leaves idle
    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state != S_IDLE))
        else $error("accepted word did not start the sequencer");

    // Gcd operands never reach zero
    a_gcd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GCD) |-> ((r_u != '0) && (r_v != '0)))
        else $error("gcd operand is zero");

    // Partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DIVN) || (r_state == S_DIVD)) |-> (r_rem < r_g))
        else $error("division remainder out of range");

    // Error words carry an all-zero fraction
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.error) |-> ((o_out.res_num == '0) && (o_out.res_den == '0)))
        else $error("error word with nonzero fraction");

endmodule
